[rtl/bptc_pkg.sv]
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, register indexes and pipeline control types for the
// barometric pressure and temperature compensation block.
// ----------------------------------------------------------------------------
package bptc_pkg;

    // Field widths.
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS     = 3'd0,
        REG_OFF      = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5
    } t_cfg_idx;

    // Internal datapath widths.
    localparam int DT_W   = RAW_W + 1;          // raw_temp - tref*2^8
    localparam int PROD_W = DT_W + COEF_W + 1;  // dT times a coefficient
    localparam int Q_W    = PROD_W - 23;        // temperature minus 2000
    localparam int SQ_W   = 2 * Q_W;            // square of Q_W values
    localparam int ACC_W  = 40;                 // OFF, SENS and their corrections
    localparam int SPLIT  = 20;                 // SENS split point for the multiply
    localparam int PPL_W  = RAW_W + 1 + SPLIT + 1;
    localparam int PPH_W  = RAW_W + 1 + (ACC_W - SPLIT);
    localparam int PFULL_W = 64;
    localparam int PV_W   = PFULL_W - 21;
    localparam int DIFF_W = PV_W + 1;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = TEMP_W'(2000);
    localparam logic signed [Q_W-1:0]    COLD2_OFS = Q_W'(3500);

    // Pipeline stages.
    localparam int NUM_STAGES = 9;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

[rtl/bptc_pipe_ctl.sv]
// ----------------------------------------------------------------------------
// bptc_pipe_ctl
// Valid bits and load enables for the compensation pipeline. A stage loads
// when it is empty or when the stage after it moves, so bubbles collapse
// and a stalled output only holds back stages that are full.
// ----------------------------------------------------------------------------
module bptc_pipe_ctl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    output bptc_pkg::t_pipe_ctl  o_ctl
);

    logic [bptc_pkg::NUM_STAGES-1:0] r_vld;
    logic [bptc_pkg::NUM_STAGES-1:0] n_en;

    always_comb begin
        n_en[bptc_pkg::NUM_STAGES-1] = !r_vld[bptc_pkg::NUM_STAGES-1] || !i_out_stall;
        for (int k = bptc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < bptc_pkg::NUM_STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ctl.en  = n_en;
    assign o_ctl.vld = r_vld;

endmodule

[rtl/baro_pressure_temp_compensation.sv]
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order compensation of raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
// Each transaction carries one raw pressure and one raw temperature
// conversion and produces one compensated temperature (hundredths of a
// degree) and one compensated pressure. The block is a nine-stage pipeline
// and takes a new transaction every cycle unless the output stall backs up
// into the first stage. The stages are: temperature difference, the three
// coefficient products, first-order offset and sensitivity, the two squares,
// the second-order terms, their subtraction, the split 24x40 pressure
// multiply, recombination, and the final offset and scaling. Write the six
// calibration registers only while no transaction is in flight; writes to
// indexes above five are ignored.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [bptc_pkg::COEF_W-1:0]            i_cfg_data,
    // Input channel.
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [bptc_pkg::RAW_W-1:0]             i_raw_press,
    input  logic [bptc_pkg::RAW_W-1:0]             i_raw_temp,
    // Output channel.
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [bptc_pkg::TEMP_W-1:0]     o_temp_centi,
    output logic signed [bptc_pkg::PRESS_W-1:0]    o_press_out
);

    localparam int DT_W    = bptc_pkg::DT_W;
    localparam int PROD_W  = bptc_pkg::PROD_W;
    localparam int Q_W     = bptc_pkg::Q_W;
    localparam int SQ_W    = bptc_pkg::SQ_W;
    localparam int ACC_W   = bptc_pkg::ACC_W;
    localparam int SPLIT   = bptc_pkg::SPLIT;
    localparam int RAW_W   = bptc_pkg::RAW_W;
    localparam int TEMP_W  = bptc_pkg::TEMP_W;

    // ------------------------------------------------------------------
    // Calibration registers.
    // ------------------------------------------------------------------
    logic [bptc_pkg::COEF_W-1:0] r_coef_sens;
    logic [bptc_pkg::COEF_W-1:0] r_coef_off;
    logic [bptc_pkg::COEF_W-1:0] r_coef_tcs;
    logic [bptc_pkg::COEF_W-1:0] r_coef_tco;
    logic [bptc_pkg::COEF_W-1:0] r_coef_tref;
    logic [bptc_pkg::COEF_W-1:0] r_coef_tempsens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_sens     <= '0;
            r_coef_off      <= '0;
            r_coef_tcs      <= '0;
            r_coef_tco      <= '0;
            r_coef_tref     <= '0;
            r_coef_tempsens <= '0;
        end else if (i_cfg_we) begin
            case (bptc_pkg::t_cfg_idx'(i_cfg_idx))
                bptc_pkg::REG_SENS:     r_coef_sens     <= i_cfg_data;
                bptc_pkg::REG_OFF:      r_coef_off      <= i_cfg_data;
                bptc_pkg::REG_TCS:      r_coef_tcs      <= i_cfg_data;
                bptc_pkg::REG_TCO:      r_coef_tco      <= i_cfg_data;
                bptc_pkg::REG_TREF:     r_coef_tref     <= i_cfg_data;
                bptc_pkg::REG_TEMPSENS: r_coef_tempsens <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control.
    // ------------------------------------------------------------------
    bptc_pkg::t_pipe_ctl w_ctl;

    bptc_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .o_ctl       (w_ctl)
    );

    assign o_stall = !w_ctl.en[0];
    assign o_valid = w_ctl.vld[bptc_pkg::NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: temperature difference.
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]        r1_press;
    logic signed [DT_W-1:0]  r1_dt;
    logic signed [DT_W-1:0]  n1_dt;

    assign n1_dt = $signed({1'b0, i_raw_temp}) - $signed({1'b0, r_coef_tref, 8'b0});

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r1_press <= i_raw_press;
            r1_dt    <= n1_dt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three coefficient products.
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r2_press;
    logic signed [PROD_W-1:0]  r2_p_ts;
    logic signed [PROD_W-1:0]  r2_p_tco;
    logic signed [PROD_W-1:0]  r2_p_tcs;

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[1]) begin
            r2_press <= r1_press;
            r2_p_ts  <= r1_dt * $signed({1'b0, r_coef_tempsens});
            r2_p_tco <= r1_dt * $signed({1'b0, r_coef_tco});
            r2_p_tcs <= r1_dt * $signed({1'b0, r_coef_tcs});
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: temperature, first-order offset and sensitivity.
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r3_press;
    logic signed [Q_W-1:0]     r3_q;      // temperature minus 2000
    logic signed [Q_W-1:0]     r3_qc;     // temperature plus 1500
    logic signed [TEMP_W-1:0]  r3_temp;
    logic signed [ACC_W-1:0]   r3_off;
    logic signed [ACC_W-1:0]   r3_sens;
    logic signed [Q_W-1:0]     n3_q;
    logic signed [ACC_W-1:0]   n3_off_t;
    logic signed [ACC_W-1:0]   n3_sens_t;

    // Arithmetic right shifts are taken as part-selects of the signed product.
    assign n3_q      = r2_p_ts[PROD_W-1:23];
    assign n3_off_t  = ACC_W'($signed(r2_p_tco[PROD_W-1:7]));
    assign n3_sens_t = ACC_W'($signed(r2_p_tcs[PROD_W-1:8]));

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[2]) begin
            r3_press <= r2_press;
            r3_q     <= n3_q;
            r3_qc    <= n3_q + bptc_pkg::COLD2_OFS;
            r3_temp  <= TEMP_W'(n3_q) + bptc_pkg::TEMP_BASE;
            r3_off   <= n3_off_t + $signed(ACC_W'({r_coef_off, 16'b0}));
            r3_sens  <= n3_sens_t + $signed(ACC_W'({r_coef_sens, 15'b0}));
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares for the cold and very cold corrections.
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r4_press;
    logic                      r4_cold;
    logic                      r4_vcold;
    logic signed [TEMP_W-1:0]  r4_temp;
    logic signed [ACC_W-1:0]   r4_off;
    logic signed [ACC_W-1:0]   r4_sens;
    logic signed [SQ_W-1:0]    r4_d;
    logic signed [SQ_W-1:0]    r4_e;

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[3]) begin
            r4_press <= r3_press;
            r4_cold  <= r3_q[Q_W-1];
            r4_vcold <= r3_qc[Q_W-1];
            r4_temp  <= r3_temp;
            r4_off   <= r3_off;
            r4_sens  <= r3_sens;
            r4_d     <= r3_q * r3_q;
            r4_e     <= r3_qc * r3_qc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: second-order terms. Squares are never negative, so the
    // floor divisions are plain shifts.
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r5_press;
    logic signed [TEMP_W-1:0]  r5_temp;
    logic signed [ACC_W-1:0]   r5_off;
    logic signed [ACC_W-1:0]   r5_sens;
    logic [ACC_W-1:0]          r5_off2;
    logic [ACC_W-1:0]          r5_sens2;
    logic [ACC_W-1:0]          n5_d;
    logic [ACC_W-1:0]          n5_e;
    logic [ACC_W-1:0]          n5_d5;
    logic [ACC_W-1:0]          n5_e7;
    logic [ACC_W-1:0]          n5_e11;
    logic [ACC_W-1:0]          n5_off2;
    logic [ACC_W-1:0]          n5_sens2;

    always_comb begin
        n5_d     = ACC_W'(unsigned'(r4_d));
        n5_e     = ACC_W'(unsigned'(r4_e));
        n5_d5    = n5_d + (n5_d << 2);
        n5_e7    = (n5_e << 3) - n5_e;
        n5_e11   = (n5_e << 3) + (n5_e << 1) + n5_e;
        n5_off2  = '0;
        n5_sens2 = '0;
        if (r4_cold) begin
            n5_off2  = n5_d5 >> 1;
            n5_sens2 = n5_d5 >> 2;
            if (r4_vcold) begin
                n5_off2  = n5_off2 + n5_e7;
                n5_sens2 = n5_sens2 + (n5_e11 >> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[4]) begin
            r5_press <= r4_press;
            r5_temp  <= r4_temp;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_off2  <= n5_off2;
            r5_sens2 <= n5_sens2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: corrected offset and sensitivity.
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r6_press;
    logic signed [TEMP_W-1:0]  r6_temp;
    logic signed [ACC_W-1:0]   r6_off;
    logic signed [ACC_W-1:0]   r6_sens;

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[5]) begin
            r6_press <= r5_press;
            r6_temp  <= r5_temp;
            r6_off   <= r5_off - $signed(r5_off2);
            r6_sens  <= r5_sens - $signed(r5_sens2);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: pressure times sensitivity, as two partial products over
    // the low (unsigned) and high (signed) halves of the sensitivity.
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]           r7_temp;
    logic signed [ACC_W-1:0]            r7_off;
    logic signed [bptc_pkg::PPL_W-1:0]  r7_pp_lo;
    logic signed [bptc_pkg::PPH_W-1:0]  r7_pp_hi;

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[6]) begin
            r7_temp  <= r6_temp;
            r7_off   <= r6_off;
            r7_pp_lo <= $signed({1'b0, r6_press}) * $signed({1'b0, r6_sens[SPLIT-1:0]});
            r7_pp_hi <= $signed({1'b0, r6_press}) * $signed(r6_sens[ACC_W-1:SPLIT]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: recombine the full product and scale by 2^-21.
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]             r8_temp;
    logic signed [ACC_W-1:0]              r8_off;
    logic signed [bptc_pkg::PV_W-1:0]     r8_pv;
    logic signed [bptc_pkg::PFULL_W-1:0]  n8_prod;

    assign n8_prod = ($signed(bptc_pkg::PFULL_W'(r7_pp_hi)) <<< SPLIT)
                   + $signed(bptc_pkg::PFULL_W'(unsigned'(r7_pp_lo)));

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[7]) begin
            r8_temp <= r7_temp;
            r8_off  <= r7_off;
            r8_pv   <= n8_prod[bptc_pkg::PFULL_W-1:21];
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: subtract the offset and scale by 2^-15. The result is at
    // most 29 bits wide for any register and input values, so it always
    // lies inside the 32-bit range and sign extension replaces saturation.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::DIFF_W-1:0]   n9_diff;
    logic signed [TEMP_W-1:0]             r9_temp;
    logic signed [bptc_pkg::PRESS_W-1:0]  r9_press;

    assign n9_diff = $signed(bptc_pkg::DIFF_W'(r8_pv)) - $signed(bptc_pkg::DIFF_W'(r8_off));

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[8]) begin
            r9_temp  <= r8_temp;
            r9_press <= bptc_pkg::PRESS_W'($signed(n9_diff[bptc_pkg::DIFF_W-1:15]));
        end
    end

    assign o_temp_centi = r9_temp;
    assign o_press_out  = r9_press;

endmodule
